@@ hdl/gpm_pkg.sv @@
`timescale 1ns / 1ps

package gpm_pkg;

  localparam int MAX_SEGMENTS = 100;
  localparam int SEGCFG_W     = 8;
  localparam int SEG_W        = 7;
  localparam int AXIS_W       = 2;
  localparam int SCALE_W      = 16;
  localparam int CORNER_W     = 3;
  localparam int LAST_CORNER  = 5;
  localparam int FRAC_BITS    = 16;
  localparam int FRAC_W       = SEG_W + FRAC_BITS;
  localparam int ACC_W        = FRAC_W + 2;
  localparam int PROD_W       = ACC_W + SCALE_W + 1;
  localparam int POS_W        = 26;
  localparam int TEX_W        = 17;
  localparam int IDX_W        = 14;
  localparam int ROUND_SHIFT  = 8;
  localparam int ROUND_BIAS   = 1 << (ROUND_SHIFT - 1);
  localparam int ONE_Q16      = 1 << FRAC_BITS;
  localparam int HALF_Q16     = 1 << (FRAC_BITS - 1);
  localparam int QDEPTH       = 2;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int NCOMP        = 3;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] PICK_A = 2'd0;
  localparam logic [1:0] PICK_B = 2'd1;
  localparam logic [1:0] PICK_C = 2'd2;
  localparam logic [1:0] PICK_D = 2'd3;

  typedef enum logic [2:0] {
    REG_HSEG    = 3'd0,
    REG_VSEG    = 3'd1,
    REG_HAXIS   = 3'd2,
    REG_VAXIS   = 3'd3,
    REG_FLIP    = 3'd4,
    REG_SCALE_X = 3'd5,
    REG_SCALE_Y = 3'd6,
    REG_SCALE_Z = 3'd7
  } reg_idx_t;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_CORNER = 1'b1
  } kind_t;

  typedef struct packed {
    logic [SEG_W-1:0]   hseg;
    logic [SEG_W-1:0]   vseg;
    logic [AXIS_W-1:0]  haxis;
    logic [AXIS_W-1:0]  vaxis;
    logic               flip;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [SCALE_W-1:0] scale_z;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEG_W-1:0] row;
    logic [SEG_W-1:0] col;
    logic             last;
  } job_t;

  function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEGCFG_W-1:0] s);
    logic [SEG_W-1:0] r;
    if (s == '0) begin
      r = SEG_W'(1);
    end else if (s > SEGCFG_W'(MAX_SEGMENTS)) begin
      r = SEG_W'(MAX_SEGMENTS);
    end else begin
      r = s[SEG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] corner_pick(input logic flip,
                                             input logic [CORNER_W-1:0] idx);
    logic [1:0] p;
    if (!flip) begin
      case (idx)
        3'd0:    p = PICK_A;
        3'd1:    p = PICK_B;
        3'd2:    p = PICK_C;
        3'd3:    p = PICK_C;
        3'd4:    p = PICK_B;
        3'd5:    p = PICK_D;
        default: p = PICK_A;
      endcase
    end else begin
      case (idx)
        3'd0:    p = PICK_A;
        3'd1:    p = PICK_C;
        3'd2:    p = PICK_B;
        3'd3:    p = PICK_C;
        3'd4:    p = PICK_D;
        3'd5:    p = PICK_B;
        default: p = PICK_A;
      endcase
    end
    return p;
  endfunction

endpackage

@@ hdl/grid_plane_mesh_generator.sv @@
`timescale 1ns / 1ps
// A pull that yields a record queues one word; others queue none. Up to two
// words queue ahead. The back end takes one word at a time through the two
// bit-serial fraction dividers (one quotient bit per cycle, 23 bits), multiply
// and writeback, which waits for a free output slot, then pops the next word.
// Reset: synchronous; registers take their listed values, generator idles.

module grid_plane_mesh_generator import gpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    restart,
  output logic                    rec_valid,
  input  logic                    rec_ready,
  output logic                    kind,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic [TEX_W-1:0]        tex_u,
  output logic [TEX_W-1:0]        tex_v,
  output logic [IDX_W-1:0]        vertex_index,
  output logic                    last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  logic [SEGCFG_W-1:0]        hseg_reg, vseg_reg;
  logic [AXIS_W-1:0]          haxis_reg, vaxis_reg;
  logic                       flip_reg;
  logic [SCALE_W-1:0]         scale_x_reg, scale_y_reg, scale_z_reg;
  reg_idx_t                   reg_idx;
  logic                       wr_en;
  cfg_t                       cfg;
  logic                       push, pop, q_empty, q_full;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  job_t                       wr_job, rd_job;
  kind_t                      rec_kind;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hseg_reg    <= SEGCFG_W'(1);
      vseg_reg    <= SEGCFG_W'(1);
      haxis_reg   <= AXIS_X;
      vaxis_reg   <= AXIS_Z;
      flip_reg    <= 1'b0;
      scale_x_reg <= SCALE_W'(256);
      scale_y_reg <= SCALE_W'(256);
      scale_z_reg <= SCALE_W'(256);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HSEG:    hseg_reg    <= pwdata[SEGCFG_W-1:0];
        REG_VSEG:    vseg_reg    <= pwdata[SEGCFG_W-1:0];
        REG_HAXIS:   haxis_reg   <= pwdata[AXIS_W-1:0];
        REG_VAXIS:   vaxis_reg   <= pwdata[AXIS_W-1:0];
        REG_FLIP:    flip_reg    <= pwdata[0];
        REG_SCALE_X: scale_x_reg <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_reg <= pwdata[SCALE_W-1:0];
        REG_SCALE_Z: scale_z_reg <= pwdata[SCALE_W-1:0];
        default:     flip_reg    <= flip_reg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HSEG:    prdata = DATA_W'(hseg_reg);
      REG_VSEG:    prdata = DATA_W'(vseg_reg);
      REG_HAXIS:   prdata = DATA_W'(haxis_reg);
      REG_VAXIS:   prdata = DATA_W'(vaxis_reg);
      REG_FLIP:    prdata = DATA_W'(flip_reg);
      REG_SCALE_X: prdata = DATA_W'(scale_x_reg);
      REG_SCALE_Y: prdata = DATA_W'(scale_y_reg);
      REG_SCALE_Z: prdata = DATA_W'(scale_z_reg);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.hseg    = clamp_seg(hseg_reg);
    cfg.vseg    = clamp_seg(vseg_reg);
    cfg.haxis   = haxis_reg;
    cfg.vaxis   = vaxis_reg;
    cfg.flip    = flip_reg;
    cfg.scale_x = scale_x_reg;
    cfg.scale_y = scale_y_reg;
    cfg.scale_z = scale_z_reg;
  end

  gpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .restart   (restart),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  gpm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (q_empty),
    .full   (q_full),
    .count  (q_count)
  );

  gpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_job     (rd_job),
    .pop       (pop),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_kind  (rec_kind),
    .rec_pos_x (pos_x),
    .rec_pos_y (pos_y),
    .rec_pos_z (pos_z),
    .rec_tex_u (tex_u),
    .rec_tex_v (tex_v),
    .rec_index (vertex_index),
    .rec_last  (last)
  );

  assign kind = rec_kind;

  a_restart_queued: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && restart |=> q_count != '0)
    else $error("restart word not queued");

  a_vertex_not_last: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_kind == KIND_VERTEX |-> !last)
    else $error("vertex word marked last");

  a_corner_no_pos: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_kind == KIND_CORNER |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("corner word carries a position");

endmodule

@@ hdl/gpm_front.sv @@
`timescale 1ns / 1ps

module gpm_front import gpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  logic restart,
  input  cfg_t cfg,
  input  logic q_full,
  output logic push,
  output job_t job
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_VERT = 4'b0010,
    PH_CORN = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t              phase, phase_next;
  logic [SEG_W-1:0]    row, row_next;
  logic [SEG_W-1:0]    col, col_next;
  logic [CORNER_W-1:0] corner, corner_next;
  logic                accept;
  logic                col_end, row_end;
  logic                last_col, last_row;
  logic [1:0]          pick;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  assign col_end = ((SEG_W+1)'(col) + (SEG_W+1)'(1)) >= (SEG_W+1)'(cfg.hseg);
  assign row_end = ((SEG_W+1)'(row) + (SEG_W+1)'(1)) >= (SEG_W+1)'(cfg.vseg);

  always_comb begin
    phase_next  = phase;
    row_next    = row;
    col_next    = col;
    corner_next = corner;
    if (restart) begin
      phase_next  = PH_VERT;
      row_next    = '0;
      col_next    = '0;
      corner_next = '0;
    end else begin
      unique case (phase)
        PH_VERT: begin
          if (col >= cfg.hseg) begin
            col_next = '0;
            if (row >= cfg.vseg) begin
              row_next    = '0;
              corner_next = '0;
              phase_next  = PH_CORN;
            end else begin
              row_next = row + SEG_W'(1);
            end
          end else begin
            col_next = col + SEG_W'(1);
          end
        end
        PH_CORN: begin
          if (corner >= CORNER_W'(LAST_CORNER)) begin
            corner_next = '0;
            if (col_end) begin
              col_next = '0;
              if (row_end) begin
                row_next   = '0;
                phase_next = PH_DONE;
              end else begin
                row_next = row + SEG_W'(1);
              end
            end else begin
              col_next = col + SEG_W'(1);
            end
          end else begin
            corner_next = corner + CORNER_W'(1);
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  assign last_col = ((SEG_W+1)'(col_next) + (SEG_W+1)'(1)) >= (SEG_W+1)'(cfg.hseg);
  assign last_row = ((SEG_W+1)'(row_next) + (SEG_W+1)'(1)) >= (SEG_W+1)'(cfg.vseg);
  assign pick     = corner_pick(cfg.flip, corner_next);

  always_comb begin
    push = accept && (phase_next == PH_VERT || phase_next == PH_CORN);
    if (phase_next == PH_CORN) begin
      job.kind = KIND_CORNER;
      job.row  = row_next + SEG_W'(pick[0]);
      job.col  = col_next + SEG_W'(pick[1]);
      job.last = (corner_next >= CORNER_W'(LAST_CORNER)) && last_col && last_row;
    end else begin
      job.kind = KIND_VERTEX;
      job.row  = row_next;
      job.col  = col_next;
      job.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      row    <= '0;
      col    <= '0;
      corner <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      row    <= row_next;
      col    <= col_next;
      corner <= corner_next;
    end
  end

endmodule

@@ hdl/gpm_queue.sv @@
`timescale 1ns / 1ps

module gpm_queue import gpm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  job_t                        wr_job,
  input  logic                        pop,
  output job_t                        rd_job,
  output logic                        empty,
  output logic                        full,
  output logic [$clog2(QDEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(QDEPTH));
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/gpm_div.sv @@
`timescale 1ns / 1ps

module gpm_div import gpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SEG_W-1:0]  k,
  input  logic [SEG_W-1:0]  n,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic                running;
  logic [STEP_W-1:0]   steps;
  logic [SEG_W-1:0]    dvs;
  logic [SEG_W-1:0]    rem;
  logic [FRAC_W-1:0]   num;
  logic [SEG_W:0]      trial;
  logic                ge;

  assign trial = {rem, num[FRAC_W-1]};
  assign ge    = trial >= (SEG_W+1)'(dvs);
  assign quot  = num;

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= n;
      rem <= '0;
      num <= {k, FRAC_BITS'(n >> 1)};
    end else if (running) begin
      rem <= ge ? SEG_W'(trial - (SEG_W+1)'(dvs)) : trial[SEG_W-1:0];
      num <= {num[FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (steps == STEP_W'(1));
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(FRAC_W);
      end else if (running) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hdl/gpm_back.sv @@
`timescale 1ns / 1ps

module gpm_back import gpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    q_empty,
  input  job_t                    q_job,
  output logic                    pop,
  output logic                    rec_valid,
  input  logic                    rec_ready,
  output kind_t                   rec_kind,
  output logic signed [POS_W-1:0] rec_pos_x,
  output logic signed [POS_W-1:0] rec_pos_y,
  output logic signed [POS_W-1:0] rec_pos_z,
  output logic [TEX_W-1:0]        rec_tex_u,
  output logic [TEX_W-1:0]        rec_tex_v,
  output logic [IDX_W-1:0]        rec_index,
  output logic                    rec_last
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_MUL  = 4'b0100,
    B_WB   = 4'b1000
  } bstate_t;

  bstate_t                    state;
  job_t                       cur;
  logic                       du_done, dv_done;
  logic [FRAC_W-1:0]          fu_q, fv_q;
  logic [FRAC_W-1:0]          fu, fv;
  logic signed [ACC_W-1:0]    acc [NCOMP];
  logic signed [ACC_W-1:0]    acc_next [NCOMP];
  logic signed [PROD_W-1:0]   prod [NCOMP];
  logic signed [PROD_W-1:0]   rnd [NCOMP];
  logic [SCALE_W-1:0]         scale [NCOMP];
  logic [2*SEG_W+1:0]         idx_full;
  logic                       slot_free;

  assign pop       = (state == B_IDLE) && !q_empty;
  assign slot_free = !rec_valid || rec_ready;

  assign scale[0] = cfg.scale_x;
  assign scale[1] = cfg.scale_y;
  assign scale[2] = cfg.scale_z;

  gpm_div u_div_u (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .k     (q_job.col),
    .n     (cfg.hseg),
    .done  (du_done),
    .quot  (fu_q)
  );

  gpm_div u_div_v (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .k     (q_job.row),
    .n     (cfg.vseg),
    .done  (dv_done),
    .quot  (fv_q)
  );

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      acc_next[i] = (AXIS_W'(i) == AXIS_Y) ? '0 : -ACC_W'(HALF_Q16);
      if (cfg.haxis == AXIS_W'(i)) begin
        acc_next[i] = acc_next[i] + ACC_W'(fu_q);
      end
      if (cfg.vaxis == AXIS_W'(i)) begin
        acc_next[i] = acc_next[i] + ACC_W'(fv_q);
      end
    end
    for (int i = 0; i < NCOMP; i++) begin
      rnd[i] = prod[i] + PROD_W'(ROUND_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (state == B_DIV && du_done && dv_done) begin
      fu <= fu_q;
      fv <= fv_q;
      for (int i = 0; i < NCOMP; i++) begin
        acc[i] <= acc_next[i];
      end
    end
    if (state == B_MUL) begin
      for (int i = 0; i < NCOMP; i++) begin
        prod[i] <= PROD_W'(acc[i]) * PROD_W'($signed({1'b0, scale[i]}));
      end
      idx_full <= (2*SEG_W+2)'(cur.row) * (2*SEG_W+2)'(cfg.hseg + SEG_W'(1))
                  + (2*SEG_W+2)'(cur.col);
    end
    if (state == B_WB && slot_free) begin
      rec_kind  <= cur.kind;
      rec_tex_u <= fu[TEX_W-1:0];
      rec_tex_v <= TEX_W'(ONE_Q16) - fv[TEX_W-1:0];
      rec_index <= idx_full[IDX_W-1:0];
      rec_last  <= cur.last;
      if (cur.kind == KIND_CORNER) begin
        rec_pos_x <= '0;
        rec_pos_y <= '0;
        rec_pos_z <= '0;
      end else begin
        rec_pos_x <= rnd[0][ROUND_SHIFT +: POS_W];
        rec_pos_y <= rnd[1][ROUND_SHIFT +: POS_W];
        rec_pos_z <= rnd[2][ROUND_SHIFT +: POS_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rec_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (du_done && dv_done) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          state <= B_WB;
        end
        B_WB: begin
          if (slot_free) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (state == B_WB && slot_free) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gpm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_PRINTS = 40;
  localparam int RANDOM_QUOTA = 390;

  localparam logic [11:0] WIND_KEEP = {PICK_D, PICK_B, PICK_C, PICK_C, PICK_B, PICK_A};
  localparam logic [11:0] WIND_FLIP = {PICK_B, PICK_D, PICK_C, PICK_B, PICK_C, PICK_A};

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_VERT,
    GEN_CORN,
    GEN_DONE
  } gen_phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [IDX_W-1:0]   vidx;
    logic               last;
  } mesh_rec_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic restart = 1'b0;
  logic rec_valid;
  logic rec_ready = 1'b0;
  logic kind;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic [IDX_W-1:0] vertex_index;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  grid_plane_mesh_generator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .restart(restart),
    .rec_valid(rec_valid), .rec_ready(rec_ready),
    .kind(kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v), .vertex_index(vertex_index), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mirror of the generator configuration and stream position
  logic [SEGCFG_W-1:0] cfg_hseg = 8'd1;
  logic [SEGCFG_W-1:0] cfg_vseg = 8'd1;
  logic [AXIS_W-1:0]   cfg_haxis = AXIS_X;
  logic [AXIS_W-1:0]   cfg_vaxis = AXIS_Z;
  logic                cfg_flip = 1'b0;
  logic [SCALE_W-1:0]  cfg_scale_x = 16'd256;
  logic [SCALE_W-1:0]  cfg_scale_y = 16'd256;
  logic [SCALE_W-1:0]  cfg_scale_z = 16'd256;
  gen_phase_t  gen_phase = GEN_IDLE;
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  int unsigned corner_cnt = 0;

  mesh_rec_t expected_recs[$];
  int errors = 0;
  int records_issued = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        rec_ready <= 1'b0;
      end else begin
        rec_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int unsigned eff_segments(input logic [SEGCFG_W-1:0] s);
    if (s == '0) return 1;
    return (s > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(s);
  endfunction

  function automatic longint q16_frac(input longint k, input longint n);
    return (k * ONE_Q16 + n / 2) / n;
  endfunction

  function automatic logic [POS_W-1:0] scale_pos(input longint acc, input longint s);
    longint p;
    p = acc * s + ROUND_BIAS;
    return POS_W'(p >>> ROUND_SHIFT);
  endfunction

  function automatic mesh_rec_t vertex_rec(input int unsigned h, input int unsigned v);
    longint acc [3];
    longint fu, fv;
    mesh_rec_t r;
    acc[0] = -HALF_Q16;
    acc[1] = 0;
    acc[2] = -HALF_Q16;
    fu = q16_frac(col_cnt, h);
    fv = q16_frac(row_cnt, v);
    if (cfg_haxis <= AXIS_Z) acc[cfg_haxis] += fu;
    if (cfg_vaxis <= AXIS_Z) acc[cfg_vaxis] += fv;
    r.kind = KIND_VERTEX;
    r.pos_x = scale_pos(acc[0], cfg_scale_x);
    r.pos_y = scale_pos(acc[1], cfg_scale_y);
    r.pos_z = scale_pos(acc[2], cfg_scale_z);
    r.tex_u = TEX_W'(fu);
    r.tex_v = TEX_W'(ONE_Q16 - fv);
    r.vidx = IDX_W'(row_cnt * (h + 1) + col_cnt);
    r.last = 1'b0;
    return r;
  endfunction

  function automatic mesh_rec_t corner_rec(input int unsigned h, input int unsigned v);
    logic [11:0] order;
    logic [1:0] pick;
    int unsigned r_at, c_at;
    mesh_rec_t r;
    order = cfg_flip ? WIND_FLIP : WIND_KEEP;
    pick = order[2 * (corner_cnt % 6) +: 2];
    r_at = row_cnt + pick[0];
    c_at = col_cnt + pick[1];
    r.kind = KIND_CORNER;
    r.pos_x = '0;
    r.pos_y = '0;
    r.pos_z = '0;
    r.tex_u = TEX_W'(q16_frac(c_at, h));
    r.tex_v = TEX_W'(ONE_Q16 - q16_frac(r_at, v));
    r.vidx = IDX_W'(r_at * (h + 1) + c_at);
    r.last = (corner_cnt >= LAST_CORNER) && (col_cnt + 1 >= h) && (row_cnt + 1 >= v);
    return r;
  endfunction

  task automatic advance_mesh(input logic rs, output bit produced);
    int unsigned h, v;
    h = eff_segments(cfg_hseg);
    v = eff_segments(cfg_vseg);
    produced = 1'b0;
    if (rs) begin
      gen_phase = GEN_VERT;
      row_cnt = 0;
      col_cnt = 0;
      corner_cnt = 0;
    end else if (gen_phase == GEN_VERT) begin
      if (col_cnt >= h) begin
        col_cnt = 0;
        if (row_cnt >= v) begin
          row_cnt = 0;
          corner_cnt = 0;
          gen_phase = GEN_CORN;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
    end else if (gen_phase == GEN_CORN) begin
      if (corner_cnt >= LAST_CORNER) begin
        corner_cnt = 0;
        if (col_cnt + 1 >= h) begin
          col_cnt = 0;
          if (row_cnt + 1 >= v) begin
            row_cnt = 0;
            gen_phase = GEN_DONE;
          end else begin
            row_cnt++;
          end
        end else begin
          col_cnt++;
        end
      end else begin
        corner_cnt++;
      end
    end else begin
      return;
    end
    if (gen_phase == GEN_VERT) begin
      expected_recs.insert(expected_recs.size(), vertex_rec(h, v));
      produced = 1'b1;
    end else if (gen_phase == GEN_CORN) begin
      expected_recs.insert(expected_recs.size(), corner_rec(h, v));
      produced = 1'b1;
    end
  endtask

  function automatic int mesh_records();
    int h, v;
    h = eff_segments(cfg_hseg);
    v = eff_segments(cfg_vseg);
    return (h + 1) * (v + 1) + 6 * h * v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycle_cnt, got, want);
  endtask

  always @(posedge clk) begin
    mesh_rec_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (expected_recs.size() == 0) begin
        report_mismatch("unexpected record", kind, '0);
      end else begin
        want = expected_recs.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
        if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
        if (pos_z !== want.pos_z) report_mismatch("pos_z", pos_z, want.pos_z);
        if (tex_u !== want.tex_u) report_mismatch("tex_u", tex_u, want.tex_u);
        if (tex_v !== want.tex_v) report_mismatch("tex_v", tex_v, want.tex_v);
        if (vertex_index !== want.vidx)
          report_mismatch("vertex_index", vertex_index, want.vidx);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // hold the word until accepted; valid stays up for the next call
  task automatic issue_pull(input logic rs);
    bit produced;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!req_ready);
    advance_mesh(rs, produced);
    if (produced) records_issued++;
  endtask

  // drop valid and let the generator run dry
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HSEG:    cfg_hseg = val[SEGCFG_W-1:0];
      REG_VSEG:    cfg_vseg = val[SEGCFG_W-1:0];
      REG_HAXIS:   cfg_haxis = val[AXIS_W-1:0];
      REG_VAXIS:   cfg_vaxis = val[AXIS_W-1:0];
      REG_FLIP:    cfg_flip = val[0];
      REG_SCALE_X: cfg_scale_x = val[SCALE_W-1:0];
      REG_SCALE_Y: cfg_scale_y = val[SCALE_W-1:0];
      REG_SCALE_Z: cfg_scale_z = val[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_segments();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 0;
    if (sel == 1) return 255;
    if (sel == 2) return 100;
    if (sel == 3) return $urandom_range(101, 254);
    if (sel == 4) return $urandom_range(6, 99);
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [DATA_W-1:0] pick_scale();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 0;
    if (sel == 1) return 'hFFFF;
    if (sel == 2) return 256;
    return $urandom_range('hFFFF);
  endfunction

  task automatic randomize_config();
    write_reg(REG_HSEG, pick_segments());
    write_reg(REG_VSEG, pick_segments());
    write_reg(REG_HAXIS, $urandom_range(3));
    write_reg(REG_VAXIS, $urandom_range(3));
    write_reg(REG_FLIP, $urandom_range(1));
    write_reg(REG_SCALE_X, pick_scale());
    write_reg(REG_SCALE_Y, pick_scale());
    write_reg(REG_SCALE_Z, pick_scale());
  endtask

  task automatic test_default_mesh();
    issue_pull(1'b0);
    issue_pull(1'b1);
    repeat (9) issue_pull(1'b0);
    issue_pull(1'b0);
    wait_idle();
  endtask

  task automatic test_axes_and_winding();
    write_reg(REG_HSEG, 2);
    write_reg(REG_VSEG, 0);
    write_reg(REG_HAXIS, DATA_W'(AXIS_Y));
    write_reg(REG_VAXIS, DATA_W'(AXIS_Y));
    write_reg(REG_FLIP, 1);
    write_reg(REG_SCALE_X, 'hFFFF);
    write_reg(REG_SCALE_Y, 0);
    write_reg(REG_SCALE_Z, 1);
    issue_pull(1'b1);
    repeat (7) issue_pull(1'b0);
    wait_idle();
    write_reg(REG_HSEG, 255);
    write_reg(REG_VSEG, 255);
    write_reg(REG_HAXIS, DATA_W'(AXIS_Z));
    write_reg(REG_VAXIS, 3);
    write_reg(REG_SCALE_Y, 'hFFFF);
    issue_pull(1'b1);
    repeat (3) issue_pull(1'b0);
    wait_idle();
  endtask

  task automatic test_midstream_resize();
    write_reg(REG_HSEG, 3);
    write_reg(REG_VSEG, 3);
    write_reg(REG_HAXIS, DATA_W'(AXIS_X));
    write_reg(REG_VAXIS, DATA_W'(AXIS_Z));
    write_reg(REG_FLIP, 0);
    issue_pull(1'b1);
    repeat (7) issue_pull(1'b0);
    wait_idle();
    write_reg(REG_HSEG, 1);
    write_reg(REG_VSEG, 1);
    repeat (12) issue_pull(1'b0);
    wait_idle();
  endtask

  // stall the receiver while the sender keeps pushing, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_HSEG, 3);
    write_reg(REG_VSEG, 2);
    hold_cycles = 400;
    issue_pull(1'b1);
    repeat (30) issue_pull(1'b0);
    wait_idle();
  endtask

  task automatic test_random_meshes(input int send_pct, input int recv_pct);
    int start, total, sel;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    start = records_issued;
    while (records_issued - start < RANDOM_QUOTA) begin
      if ($urandom_range(3) != 0) begin
        wait_idle();
        randomize_config();
      end
      total = mesh_records();
      if (total > 150) total = $urandom_range(20, 60);
      sel = $urandom_range(9);
      if (sel < 7) begin
        issue_pull(1'b1);
        repeat (total - 1 + $urandom_range(2)) issue_pull(1'b0);
      end else if (sel < 9) begin
        issue_pull(1'b1);
        repeat ($urandom_range(total)) issue_pull(1'b0);
        issue_pull(1'b1);
        repeat ($urandom_range(total)) issue_pull(1'b0);
      end else begin
        repeat ($urandom_range(5, 30)) issue_pull($urandom_range(3) == 0);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_mesh();
    test_axes_and_winding();
    test_midstream_resize();
    test_backpressure();
    test_random_meshes(0, 0);
    test_random_meshes(75, 0);
    test_random_meshes(0, 75);
    test_random_meshes(16, 16);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
